// ----- design/ptme_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Plain text to markup escaper package
// Shared types, microprogram entry points and the microcode table.
// ----------------------------------------------------------------------------
package ptme_pkg;

  localparam int unsigned PC_W = 5;

  typedef logic [PC_W-1:0] pc_t;
  typedef logic [1:0]      pad_cnt_t;

  typedef enum logic [1:0] {
    OP_NEXT     = 2'd0,
    OP_DISPATCH = 2'd1,
    OP_LOOP     = 2'd2,
    OP_END      = 2'd3
  } seq_op_t;

  typedef struct packed {
    logic       use_unit;
    logic [7:0] lit;
    seq_op_t    op;
  } ctrl_word_t;

  typedef struct packed {
    pc_t      entry;
    pc_t      target;
    pad_cnt_t cnt;
  } disp_t;

  typedef struct packed {
    logic       fire;
    logic       use_unit;
    logic [7:0] lit;
    logic       last;
  } step_t;

  localparam pc_t ENTRY_OPEN    = 5'd0;
  localparam pc_t ENTRY_END     = 5'd3;
  localparam pc_t ENTRY_NL_PARA = 5'd7;
  localparam pc_t ENTRY_NL_BR   = 5'd14;
  localparam pc_t ENTRY_NBSP    = 5'd18;
  localparam pc_t ENTRY_TAB_PAD = 5'd19;
  localparam pc_t ENTRY_LT      = 5'd21;
  localparam pc_t ENTRY_GT      = 5'd25;
  localparam pc_t ENTRY_PASS    = 5'd29;

  localparam logic [7:0] NBSP = 8'hA0;

  function automatic ctrl_word_t ucode(input pc_t pc);
    ctrl_word_t cw;
    cw = '{use_unit: 1'b0, lit: 8'h00, op: OP_END};
    case (pc)
      5'd0:  cw = '{1'b0, "<", OP_NEXT};
      5'd1:  cw = '{1'b0, "p", OP_NEXT};
      5'd2:  cw = '{1'b0, ">", OP_DISPATCH};
      5'd3:  cw = '{1'b0, "<", OP_NEXT};
      5'd4:  cw = '{1'b0, "/", OP_NEXT};
      5'd5:  cw = '{1'b0, "p", OP_NEXT};
      5'd6:  cw = '{1'b0, ">", OP_END};
      5'd7:  cw = '{1'b0, "<", OP_NEXT};
      5'd8:  cw = '{1'b0, "p", OP_NEXT};
      5'd9:  cw = '{1'b0, ">", OP_NEXT};
      5'd10: cw = '{1'b0, "<", OP_NEXT};
      5'd11: cw = '{1'b0, "/", OP_NEXT};
      5'd12: cw = '{1'b0, "p", OP_NEXT};
      5'd13: cw = '{1'b0, ">", OP_END};
      5'd14: cw = '{1'b0, "<", OP_NEXT};
      5'd15: cw = '{1'b0, "b", OP_NEXT};
      5'd16: cw = '{1'b0, "r", OP_NEXT};
      5'd17: cw = '{1'b0, ">", OP_END};
      5'd18: cw = '{1'b0, NBSP, OP_END};
      5'd19: cw = '{1'b0, NBSP, OP_NEXT};
      5'd20: cw = '{1'b0, NBSP, OP_LOOP};
      5'd21: cw = '{1'b0, "&", OP_NEXT};
      5'd22: cw = '{1'b0, "l", OP_NEXT};
      5'd23: cw = '{1'b0, "t", OP_NEXT};
      5'd24: cw = '{1'b0, ";", OP_END};
      5'd25: cw = '{1'b0, "&", OP_NEXT};
      5'd26: cw = '{1'b0, "g", OP_NEXT};
      5'd27: cw = '{1'b0, "t", OP_NEXT};
      5'd28: cw = '{1'b0, ";", OP_END};
      5'd29: cw = '{1'b1, 8'h00, OP_END};
      default: cw = '{1'b0, 8'h00, OP_END};
    endcase
    return cw;
  endfunction

endpackage

// ----- design/plain_text_to_markup_escaper_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Plain text to markup escaper
// Turns a stream of UTF-16 code units into an escaped markup stream.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake            Payload
// input    in         in_valid / in_stall   command, code_unit
// output   out        out_valid / out_stall out_unit, last_of_run
//
// Each input yields one to seven output units, one per cycle while the output
// is not stalled, from a microcode step counter.
// The next input is taken in the cycle of the previous input's last unit.
// Output stall freezes the step counter; rst clears the column state.
// ----------------------------------------------------------------------------
module plain_text_to_markup_escaper_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [15:0] code_unit,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_unit,
  output logic        last_of_run
);
  import ptme_pkg::*;

  disp_t       disp;
  step_t       step;
  logic        accept;
  logic        out_ready;
  logic [15:0] unit_held;

  assign out_ready = !out_valid || !out_stall;

  ptme_classify u_classify (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .command   (command),
    .code_unit (code_unit),
    .disp      (disp)
  );

  ptme_sequencer u_sequencer (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .disp      (disp),
    .in_stall  (in_stall),
    .accept    (accept),
    .step      (step)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      unit_held <= code_unit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step.fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step.fire) begin
      out_unit    <= step.use_unit ? unit_held : {8'h00, step.lit};
      last_of_run <= step.last;
    end
  end

endmodule

// ----- design/ptme_classify.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input classifier and column state
// Picks the microprogram routine for each input and tracks the column.
// ----------------------------------------------------------------------------
module ptme_classify (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic            command,
  input  logic [15:0]     code_unit,
  output ptme_pkg::disp_t disp
);
  import ptme_pkg::*;

  logic [1:0] column_phase, column_phase_next;
  logic       column_below_four, column_below_four_next;
  logic       text_open, text_open_next;
  logic       is_nl, is_tab, is_white;
  pc_t        target;

  assign is_nl  = (code_unit == 16'h000A);
  assign is_tab = (code_unit == 16'h0009);

  always_comb begin
    is_white = 1'b0;
    if (code_unit >= 16'h0009 && code_unit <= 16'h000D) is_white = 1'b1;
    if (code_unit == 16'h0020 || code_unit == 16'h0085 || code_unit == 16'h00A0 ||
        code_unit == 16'h1680) is_white = 1'b1;
    if (code_unit >= 16'h2000 && code_unit <= 16'h200A) is_white = 1'b1;
    if (code_unit == 16'h2028 || code_unit == 16'h2029 || code_unit == 16'h202F ||
        code_unit == 16'h205F || code_unit == 16'h3000) is_white = 1'b1;
  end

  always_comb begin
    if (command) begin
      target = ENTRY_END;
    end else if (is_nl) begin
      target = (column_phase == 2'd1 && column_below_four) ? ENTRY_NL_PARA : ENTRY_NL_BR;
    end else if (is_tab) begin
      target = (column_phase != 2'd0) ? ENTRY_TAB_PAD : ENTRY_NBSP;
    end else if (is_white) begin
      target = ENTRY_NBSP;
    end else if (code_unit == 16'h003C) begin
      target = ENTRY_LT;
    end else if (code_unit == 16'h003E) begin
      target = ENTRY_GT;
    end else begin
      target = ENTRY_PASS;
    end
  end

  assign disp.target = target;
  assign disp.entry  = text_open ? target : ENTRY_OPEN;
  assign disp.cnt    = 2'(3'd4 - {1'b0, column_phase});

  always_comb begin
    column_phase_next      = column_phase;
    column_below_four_next = column_below_four;
    text_open_next         = text_open;
    if (command) begin
      column_phase_next      = 2'd0;
      column_below_four_next = 1'b1;
      text_open_next         = 1'b0;
    end else begin
      text_open_next = 1'b1;
      if (is_nl) begin
        column_phase_next      = 2'd1;
        column_below_four_next = 1'b1;
      end else if (is_tab) begin
        if (column_phase != 2'd0) column_below_four_next = 1'b0;
        column_phase_next = 2'd1;
      end else begin
        if (column_phase == 2'd3) column_below_four_next = 1'b0;
        column_phase_next = column_phase + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_phase      <= 2'd0;
      column_below_four <= 1'b1;
      text_open         <= 1'b0;
    end else if (accept) begin
      column_phase      <= column_phase_next;
      column_below_four <= column_below_four_next;
      text_open         <= text_open_next;
    end
  end

endmodule

// ----- design/ptme_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Microcode sequencer
// Step counter over the microcode table with dispatch and padding loop.
// ----------------------------------------------------------------------------
module ptme_sequencer (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            out_ready,
  input  ptme_pkg::disp_t disp,
  output logic            in_stall,
  output logic            accept,
  output ptme_pkg::step_t step
);
  import ptme_pkg::*;

  logic       busy;
  pc_t        pc;
  pc_t        target;
  pad_cnt_t   cnt;
  ctrl_word_t cw;
  logic       fire, finish;

  assign cw     = ucode(pc);
  assign fire   = busy && out_ready;
  assign finish = fire && (cw.op == OP_END || (cw.op == OP_LOOP && cnt == 2'd1));

  assign in_stall = busy && !finish;
  assign accept   = in_valid && !in_stall;

  assign step.fire     = fire;
  assign step.use_unit = cw.use_unit;
  assign step.lit      = cw.lit;
  assign step.last     = finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (finish) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pc     <= disp.entry;
      target <= disp.target;
      cnt    <= disp.cnt;
    end else if (fire) begin
      case (cw.op)
        OP_NEXT:     pc  <= pc + 5'd1;
        OP_DISPATCH: pc  <= target;
        OP_LOOP:     cnt <= cnt - 2'd1;
        default:     pc  <= pc;
      endcase
    end
  end

endmodule
